FILE: rtl/core/assert_macros.svh
// concurrent assertion helpers, sampled on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define NSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define NSR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/nsr_pkg.sv
package nsr_pkg;

  localparam int unsigned OPERAND_W = 32;
  localparam int unsigned ROOT_W    = 24;
  localparam int unsigned STEPS_W   = 6;
  localparam int unsigned MARGIN_W  = 32;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 32'd42950;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } nsr_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } nsr_div_sts_t;

endpackage

FILE: rtl/core/nsr_divider.sv
`include "assert_macros.svh"

module nsr_divider #(
  parameter int unsigned DIVIDEND_W = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [DIVIDEND_W-1:0]          dividend,
  input  logic [nsr_pkg::OPERAND_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0]          quotient,
  output nsr_pkg::nsr_div_sts_t          sts
);
  import nsr_pkg::*;

  localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

  logic [OPERAND_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [OPERAND_W-1:0]  dvs_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [OPERAND_W:0]    trial;
  logic [OPERAND_W:0]    diff;
  logic                  fits;

  // one quotient bit a cycle, restoring form
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[OPERAND_W-1:0] : trial[OPERAND_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  `NSR_ASSERT(a_no_restart, start |-> !busy_r, "divider started while busy")
  `NSR_ASSERT(a_busy_count, busy_r |-> (cnt_r != '0), "divider busy with no bits left")
  `NSR_ASSERT_NEXT(a_done_after_busy, done_r, !busy_r && !done_r, "divider done held too long")

endmodule

FILE: rtl/core/newton_square_root_unit.sv
// Square root of an unsigned fixed-point operand (FRAC_BITS fraction bits) by Newton steps,
// starting from the larger of the operand and 1.0 and stopping once the square of the
// estimate is within cfg_wdata's margin of the operand, once the estimate stops falling,
// or after MAX_ITER steps (hit_cap then flags a margin still missed). One item at a time;
// each Newton step runs the bit-serial divider that forms (operand << FRAC_BITS) / estimate,
// and each item also passes through entry, the final square and compare, and result
// hand-over; a zero operand goes straight to hand-over. in_ready is high only between
// items, while a finished result may still sit in the output register waiting for out_ready.
`include "assert_macros.svh"

module newton_square_root_unit #(
  parameter int unsigned MAX_ITER  = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nsr_pkg::OPERAND_W-1:0]  in_operand,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nsr_pkg::ROOT_W-1:0]     out_root,
  output logic [nsr_pkg::STEPS_W-1:0]    out_steps_used,
  output logic                           out_hit_cap,
  input  logic                           cfg_we,
  input  logic [nsr_pkg::MARGIN_W-1:0]   cfg_wdata
);
  import nsr_pkg::*;

  localparam int unsigned TGT_W = OPERAND_W + FRAC_BITS;
  localparam int unsigned SQ_W  = 2 * OPERAND_W;
  localparam int unsigned SW    = $clog2(MAX_ITER + 1);
  localparam logic [OPERAND_W-1:0] ONE = OPERAND_W'(1) << FRAC_BITS;

  nsr_state_t           state_r, state_nxt;
  logic [MARGIN_W-1:0]  margin_r;
  logic [OPERAND_W-1:0] opnd_r;
  logic [OPERAND_W-1:0] est_r;
  logic [SQ_W-1:0]      sq_r;
  logic [SW-1:0]        steps_r;
  logic                 cap_r;

  logic                 out_valid_r;
  logic [ROOT_W-1:0]    out_root_r;
  logic [STEPS_W-1:0]   out_steps_r;
  logic                 out_cap_r;

  logic [TGT_W-1:0]     target;
  logic [SQ_W-1:0]      target_ext;
  logic [SQ_W-1:0]      excess;
  logic                 too_big;
  logic                 at_max;
  logic [TGT_W-1:0]     quo;
  logic                 no_fall;
  logic [OPERAND_W:0]   est_sum;
  logic [OPERAND_W-1:0] est_next;
  logic                 accept;
  logic                 div_start;
  logic                 load_out;
  nsr_div_sts_t         div_sts;

  // margin test on the registered square
  always_comb begin
    target     = {opnd_r, {FRAC_BITS{1'b0}}};
    target_ext = SQ_W'(target);
    excess     = sq_r - target_ext;
    too_big    = (sq_r > target_ext) && (excess > SQ_W'(margin_r));
    at_max     = (steps_r == SW'(MAX_ITER));
    // the new estimate is not below the old one exactly when the quotient is not
    no_fall    = (quo >= TGT_W'(est_r));
    est_sum    = {1'b0, est_r} + {1'b0, quo[OPERAND_W-1:0]};
    est_next   = est_sum[OPERAND_W:1];
  end

  nsr_divider #(
    .DIVIDEND_W(TGT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (target),
    .divisor  (est_r),
    .quotient (quo),
    .sts      (div_sts)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_operand == '0) ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_SQUARE: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (at_max || !too_big) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_sts.done) begin
          state_nxt = no_fall ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    accept    = in_ready && in_valid;
    div_start = (state_r == ST_CHECK) && !at_max && too_big;
    load_out  = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      margin_r    <= MARGIN_RESET;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        margin_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        steps_r <= '0;
      end else if (state_r == ST_DIVIDE && div_sts.done && !no_fall) begin
        steps_r <= steps_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opnd_r <= in_operand;
      cap_r  <= 1'b0;
      if (in_operand == '0) begin
        est_r <= '0;
      end else begin
        est_r <= (in_operand > ONE) ? in_operand : ONE;
      end
    end
    if (state_r == ST_SQUARE) begin
      sq_r <= est_r * est_r;
    end
    if (state_r == ST_CHECK) begin
      cap_r <= at_max && too_big;
    end
    if (state_r == ST_DIVIDE && div_sts.done && !no_fall) begin
      est_r <= est_next;
    end
    if (load_out) begin
      out_root_r  <= est_r[ROOT_W-1:0];
      out_steps_r <= STEPS_W'(steps_r);
      out_cap_r   <= cap_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_root       = out_root_r;
  assign out_steps_used = out_steps_r;
  assign out_hit_cap    = out_cap_r;

  `NSR_ASSERT(a_steps_bound, steps_r <= SW'(MAX_ITER), "step count beyond limit")
  `NSR_ASSERT(a_div_done_state, div_sts.done |-> (state_r == ST_DIVIDE),
              "divider result outside divide phase")
  `NSR_ASSERT(a_div_busy_state, div_sts.busy |-> (state_r == ST_DIVIDE),
              "divider busy outside divide phase")
  `NSR_ASSERT_NEXT(a_est_falls, (state_r == ST_DIVIDE) && (state_nxt == ST_SQUARE),
                   est_r < $past(est_r), "estimate did not fall on a counted step")
  `NSR_ASSERT_NEXT(a_zero_short, accept && (in_operand == '0),
                   (state_r == ST_FINISH) && (est_r == '0), "zero operand not short-cut")

endmodule

FILE: tb/nsr_root_checker.sv
module nsr_root_checker #(
  parameter int unsigned MAX_ITER  = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [nsr_pkg::OPERAND_W-1:0] in_operand,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [nsr_pkg::ROOT_W-1:0]    out_root,
  input  logic [nsr_pkg::STEPS_W-1:0]   out_steps_used,
  input  logic                          out_hit_cap,
  input  logic                          cfg_we,
  input  logic [nsr_pkg::MARGIN_W-1:0]  cfg_wdata,
  output int                            mismatch_count,
  output int                            outstanding
);
  import nsr_pkg::*;

  typedef struct packed {
    logic [OPERAND_W-1:0] operand;
    logic [ROOT_W-1:0]    root;
    logic [STEPS_W-1:0]   steps_used;
    logic                 hit_cap;
  } root_result_t;

  root_result_t         expected_roots[$];
  logic [MARGIN_W-1:0]  margin;

  // square of the estimate still above the scaled operand by more than the margin
  function automatic bit above_margin(input logic [63:0] est, input logic [63:0] target,
                                      input logic [MARGIN_W-1:0] stop_margin);
    logic [63:0] sq;
    sq = est * est;
    return (sq > target) && ((sq - target) > {32'd0, stop_margin});
  endfunction

  function automatic root_result_t newton_root(input logic [OPERAND_W-1:0] operand,
                                               input logic [MARGIN_W-1:0] stop_margin);
    logic [63:0]  one_fx;
    logic [63:0]  target;
    logic [63:0]  est;
    logic [63:0]  next_est;
    int unsigned  steps;
    root_result_t res;
    res = '0;
    res.operand = operand;
    if (operand == '0) return res;
    one_fx = 64'd1 << FRAC_BITS;
    target = {32'd0, operand} << FRAC_BITS;
    est    = ({32'd0, operand} > one_fx) ? {32'd0, operand} : one_fx;
    steps  = 0;
    while (steps < MAX_ITER && est != 0 && above_margin(est, target, stop_margin)) begin
      next_est = (est + target / est) >> 1;
      // estimate stopped falling: keep it, step not counted
      if (next_est >= est) break;
      est = next_est;
      steps++;
    end
    res.root       = est[ROOT_W-1:0];
    res.steps_used = steps[STEPS_W-1:0];
    res.hit_cap    = (steps >= MAX_ITER) && (est != 0) && above_margin(est, target, stop_margin);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [OPERAND_W-1:0] operand,
                                 input logic [31:0] got, input logic [31:0] want);
    $display("root mismatch (%s) for operand %h: got %0h, want %0h",
             what, operand, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    root_result_t want;
    if (!rst_n) begin
      margin = MARGIN_RESET;
      expected_roots.delete();
      outstanding <= 0;
    end else begin
      // a result can never belong to an item taken at the same edge, so pop first
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("no item outstanding", '0, {8'd0, out_root}, '0);
        end else begin
          want = expected_roots.pop_front();
          if (out_root !== want.root)
            report_mismatch("root", want.operand, {8'd0, out_root}, {8'd0, want.root});
          if (out_steps_used !== want.steps_used)
            report_mismatch("steps_used", want.operand, {26'd0, out_steps_used},
                            {26'd0, want.steps_used});
          if (out_hit_cap !== want.hit_cap)
            report_mismatch("hit_cap", want.operand, {31'd0, out_hit_cap},
                            {31'd0, want.hit_cap});
        end
      end
      if (in_valid && in_ready)
        expected_roots.push_back(newton_root(in_operand, margin));
      if (cfg_we)
        margin = cfg_wdata;
      outstanding <= expected_roots.size();
    end
  end

endmodule

FILE: tb/tb_newton_square_root_unit.sv
module tb_newton_square_root_unit;
  import nsr_pkg::*;

  localparam int unsigned MAX_ITER         = 32;
  localparam int unsigned FRAC_BITS        = 16;
  localparam int          NUM_PHASES       = 7;
  localparam int          RANDOM_PER_PHASE = 105;
  localparam int          LONG_HOLD        = 2500;
  localparam int          IDLE_LIMIT       = 20000;
  localparam int          DRAIN_CYCLES     = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [OPERAND_W-1:0] in_operand;
  logic                 out_valid;
  logic                 out_ready;
  logic [ROOT_W-1:0]    out_root;
  logic [STEPS_W-1:0]   out_steps_used;
  logic                 out_hit_cap;
  logic                 cfg_we;
  logic [MARGIN_W-1:0]  cfg_wdata;

  int mismatch_count;
  int outstanding;
  int items_sent;
  int results_taken;
  int rx_hold;

  logic [OPERAND_W-1:0] corner_operands [18] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0100, 32'h0000_8000,
    32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 32'h0002_0000, 32'h0004_0000,
    32'h0009_0000, 32'h5555_5555, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
    32'hFFFF_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  newton_square_root_unit #(
    .MAX_ITER (MAX_ITER),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operand    (in_operand),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_root      (out_root),
    .out_steps_used(out_steps_used),
    .out_hit_cap   (out_hit_cap),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  nsr_root_checker #(
    .MAX_ITER (MAX_ITER),
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operand    (in_operand),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_root      (out_root),
    .out_steps_used(out_steps_used),
    .out_hit_cap   (out_hit_cap),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a clock edge; leaves valid high after the item is taken
  task automatic offer_operand(input logic [OPERAND_W-1:0] value);
    int gap;
    gap = ((items_sent / 50) % 4 == 2) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_operand <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  initial begin
    logic [MARGIN_W-1:0]  margin;
    logic [OPERAND_W-1:0] operand;
    logic [OPERAND_W-1:0] k;
    in_valid   <= 1'b0;
    in_operand <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // first phase runs on the reset margin
      if (phase > 0) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
        case (phase)
          1:       margin = '0;
          2:       margin = '1;
          3:       margin = 32'd1;
          4:       margin = $urandom;
          5:       margin = $urandom_range(0, 32'h0010_0000);
          default: margin = MARGIN_RESET;
        endcase
        cfg_we    <= 1'b1;
        cfg_wdata <= margin;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      if (phase == 0)
        foreach (corner_operands[i]) offer_operand(corner_operands[i]);
      repeat (RANDOM_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0:       operand = ($urandom_range(0, 3) == 0) ? '0 : (32'd1 << $urandom_range(0, 31));
          1:       operand = $urandom_range(0, 32'h0000_FFFF);
          2: begin
            // exact square: root is k in units of 1/256
            k       = $urandom_range(0, 65535);
            operand = k * k;
          end
          3:       operand = $urandom >> $urandom_range(0, 31);
          4:       operand = 32'hFFFF_FFFF - $urandom_range(0, 255);
          5:       operand = 32'h0000_FF00 + $urandom_range(0, 512);
          default: operand = $urandom;
        endcase
        offer_operand(operand);
      end
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random hold per item, quiet stretches, and two long hold-offs
  initial begin
    int hold;
    out_ready <= 1'b0;
    results_taken = 0;
    rx_hold = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (out_ready) begin
        if (out_valid) begin
          results_taken++;
          if (results_taken == 20 || results_taken == 400)
            hold = LONG_HOLD;
          else if ((results_taken / 40) % 4 == 3)
            hold = 0;
          else
            hold = $urandom_range(0, 16);
          if (hold > 0) begin
            out_ready <= 1'b0;
            rx_hold = hold;
          end
        end
      end else if (rx_hold <= 1) begin
        out_ready <= 1'b1;
      end else begin
        rx_hold--;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/nsr_pkg.sv
rtl/core/nsr_divider.sv
rtl/core/newton_square_root_unit.sv
tb/nsr_root_checker.sv
tb/tb_newton_square_root_unit.sv
